### sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### sv/gscc_pkg.sv
// package: states and register indexes for the collision checker
package gscc_pkg;
    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_MARK, ST_SQRT, ST_DIVR, ST_DIVC, ST_ADDR, ST_READ,
        ST_STEP, ST_DONE
    } state_t;
    localparam logic [0:0] REG_HEIGHT = 1'b0;
    localparam logic [0:0] REG_WIDTH  = 1'b1;
    localparam int STEP_FRAC = 16;
endpackage

### sv/gscc_grid.sv
// occupancy grid memory, one bit per cell, registered read
module gscc_grid #(
    parameter int AW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);
    logic mem [2**AW];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/grid_segment_collision_check.sv
// top level: occupancy grid marking and segment collision query
//
// channel  | valid     | stall     | payload
// input    | in_valid  | in_stall  | mode, obstacle_*, from_*, to_*
// output   | out_valid | out_stall | blocked
//
// after reset the grid's 2**(row bits + col bits) cells are cleared one cell a cycle,
// during which no item is taken (configuration writes are).
// a mark writes the centre cell, then the square of cells within INFLATE_RADIUS of it, through the single write port.
// a query runs the bit-serial root (one load, 18 digits), then the two restoring divisions
// (skipped for a segment shorter than one cell), then reads each sampled point on the grid
// read port, stopping at the first occupied or outside point, and then presents the result.
// the block takes no item until the result has been transferred.
module grid_segment_collision_check #(
    parameter int GRID_ROWS = 256,
    parameter int GRID_COLS = 256,
    parameter int INFLATE_RADIUS = 4,
    parameter int COORD_FRACTION_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [7:0]         obstacle_row,
    input  logic [7:0]         obstacle_col,
    input  logic signed [16:0] from_row,
    input  logic signed [16:0] from_col,
    input  logic signed [16:0] to_row,
    input  logic signed [16:0] to_col,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               blocked
);
    `include "assert_macros.svh"
    localparam int RB = $clog2(GRID_ROWS);
    localparam int CB = $clog2(GRID_COLS);
    localparam int AW = RB + CB;
    localparam int SH = gscc_pkg::STEP_FRAC - COORD_FRACTION_BITS;
    localparam int SPAN = 2 * INFLATE_RADIUS + 1;
    localparam int KB = $clog2(SPAN + 1);
    // position width: 17-bit coordinate shifted by SH plus growth
    localparam int PW = 17 + SH + 3;
    localparam int DW = 18 + SH;   // |d| scaled
    localparam int DIW = $clog2(DW);
    localparam int NW = 18;        // sqrt of 36-bit value
    localparam int QW = DW;
    localparam logic [8:0] RST_LIM = 9'd256;

    gscc_pkg::state_t state_reg, state_next;
    logic [8:0] height_reg, width_reg;
    logic [AW:0] clr_reg, clr_next;
    logic mark_c_reg, mark_c_next; // centre written
    logic [KB-1:0] ka_reg, ka_next, kb_reg, kb_next;
    logic [7:0] orow_reg, ocol_reg;
    logic signed [PW-1:0] pr_reg, pr_next, pc_reg, pc_next;
    logic signed [17:0] dr_reg, dc_reg;
    logic signed [16:0] to_row_r, to_col_r;
    logic [37:0] rem_reg, rem_next;
    logic [NW-1:0] root_reg, root_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [DW-1:0] drem_reg, drem_next;
    logic signed [PW-1:0] sr_reg, sr_next, sc_reg, sc_next;
    logic [NW-1:0] n_reg, n_next;
    logic short_reg, short_next;
    logic out_valid_reg, out_valid_next, blocked_reg, blocked_next;
    logic cell_out_reg, cell_out_next;

    logic [8:0] lim_r, lim_c;
    always_comb
    begin
        lim_r = (int'(height_reg) > GRID_ROWS) ? 9'(GRID_ROWS) : height_reg;
        lim_c = (int'(width_reg) > GRID_COLS) ? 9'(GRID_COLS) : width_reg;
    end

    // config port
    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[2])
            gscc_pkg::REG_HEIGHT: prdata = {23'd0, height_reg};
            gscc_pkg::REG_WIDTH:  prdata = {23'd0, width_reg};
            default:              prdata = 32'd0;
        endcase
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= RST_LIM;
            width_reg  <= RST_LIM;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            case (paddr[2])
                gscc_pkg::REG_HEIGHT: height_reg <= pwdata[8:0];
                gscc_pkg::REG_WIDTH:  width_reg  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    logic accept;
    assign in_stall = (state_reg != gscc_pkg::ST_IDLE) || out_valid_reg;
    assign accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign blocked = blocked_reg;

    // grid
    logic we, wdata, rdata;
    logic [AW-1:0] waddr, raddr;
    gscc_grid #(.AW(AW)) u_grid (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // mark cell
    logic signed [10:0] mr, mc;
    logic minside;
    always_comb
    begin
        mr = $signed({3'd0, orow_reg}) + $signed(11'(ka_reg)) - $signed(11'(INFLATE_RADIUS));
        mc = $signed({3'd0, ocol_reg}) + $signed(11'(kb_reg)) - $signed(11'(INFLATE_RADIUS));
        minside = (mr > 0) && (mc > 0) && (mr < $signed({2'b0, lim_r}))
                  && (mc < $signed({2'b0, lim_c}));
    end

    // point cell
    logic signed [PW-1:0] ip_r, ip_c;
    logic pout;
    always_comb
    begin
        ip_r = pr_reg >>> gscc_pkg::STEP_FRAC;
        ip_c = pc_reg >>> gscc_pkg::STEP_FRAC;
        pout = (ip_r < 1) || (ip_c < 1) || (ip_r >= $signed(PW'(lim_r)))
               || (ip_c >= $signed(PW'(lim_c)));
    end

    always_comb
    begin
        we = 1'b0;
        wdata = 1'b1;
        waddr = '0;
        raddr = {ip_r[RB-1:0], ip_c[CB-1:0]};
        if (state_reg == gscc_pkg::ST_CLEAR)
        begin
            we = 1'b1;
            wdata = 1'b0;
            waddr = clr_reg[AW-1:0];
        end
        else if (state_reg == gscc_pkg::ST_MARK)
        begin
            if (!mark_c_reg)
            begin
                we = ({8'd0, orow_reg} < 16'(GRID_ROWS)) && ({8'd0, ocol_reg} < 16'(GRID_COLS));
                waddr = {RB'(orow_reg), CB'(ocol_reg)};
            end
            else
            begin
                we = minside;
                waddr = {mr[RB-1:0], mc[CB-1:0]};
            end
        end
    end

    // division step unit: restoring division bit, shared by the row and column divisions
    logic [DW-1:0] dnum_abs;
    logic [DW:0] dtrial;
    logic [DW-1:0] dsrc;
    logic [DIW-1:0] didx;
    always_comb
    begin
        dsrc = (state_reg == gscc_pkg::ST_DIVR)
               ? DW'(dr_reg[17] ? -dr_reg : dr_reg) << SH
               : DW'(dc_reg[17] ? -dc_reg : dc_reg) << SH;
        dnum_abs = dsrc;
        didx = DIW'(cnt_reg - 6'd1);
        dtrial = {drem_reg, dnum_abs[didx]} - {1'b0, DW'(n_reg)};
    end

    logic [35:0] d2;
    assign d2 = 36'(dr_reg) * 36'(dr_reg) + 36'(dc_reg) * 36'(dc_reg);

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        mark_c_next = mark_c_reg;
        ka_next = ka_reg;
        kb_next = kb_reg;
        pr_next = pr_reg;
        pc_next = pc_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        drem_next = drem_reg;
        sr_next = sr_reg;
        sc_next = sc_reg;
        n_next = n_reg;
        short_next = short_reg;
        out_valid_next = out_valid_reg && out_stall;
        blocked_next = blocked_reg;
        cell_out_next = cell_out_reg;
        case (state_reg)
            gscc_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(2**AW - 1))
                    state_next = gscc_pkg::ST_IDLE;
            end
            gscc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mark_c_next = 1'b0;
                    ka_next = '0;
                    kb_next = '0;
                    pr_next = PW'(from_row) <<< SH;
                    pc_next = PW'(from_col) <<< SH;
                    state_next = mode ? gscc_pkg::ST_SQRT : gscc_pkg::ST_MARK;
                    cnt_next = 6'd0;
                end
            end
            gscc_pkg::ST_MARK:
            begin
                if (!mark_c_reg)
                    mark_c_next = 1'b1;
                else if (kb_reg == KB'(SPAN - 1))
                begin
                    kb_next = '0;
                    ka_next = ka_reg + 1'b1;
                    if (ka_reg == KB'(SPAN - 1))
                        state_next = gscc_pkg::ST_IDLE;
                end
                else
                    kb_next = kb_reg + 1'b1;
            end
            gscc_pkg::ST_SQRT:
            begin
                // the load step takes d2, then 18 digit steps follow
                if (cnt_reg == 6'd0)
                begin
                    short_next = d2 < (36'd1 << (2 * COORD_FRACTION_BITS));
                    rem_next = {2'b0, d2};
                    root_next = '0;
                    cnt_next = 6'd18;
                end
                else
                begin
                    if (rem_reg >= {18'd0, root_reg, 2'b01} << (2 * (cnt_reg - 1)))
                    begin
                        rem_next = rem_reg - ({18'd0, root_reg, 2'b01} << (2 * (cnt_reg - 1)));
                        root_next = {root_reg[NW-2:0], 1'b1};
                    end
                    else
                        root_next = {root_reg[NW-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == 6'd1)
                    begin
                        if (short_reg)
                        begin
                            n_next = NW'(2);
                            sr_next = (PW'(to_row_r) <<< SH) - pr_reg;
                            sc_next = (PW'(to_col_r) <<< SH) - pc_reg;
                            state_next = gscc_pkg::ST_READ;
                        end
                        else
                        begin
                            state_next = gscc_pkg::ST_DIVR;
                            cnt_next = 6'(DW);
                            drem_next = '0;
                            quo_next = '0;
                        end
                    end
                end
                if (cnt_reg == 6'd1 && !short_reg)
                    n_next = NW'({root_next} >> COORD_FRACTION_BITS);
            end
            gscc_pkg::ST_DIVR, gscc_pkg::ST_DIVC:
            begin
                if (cnt_reg == 6'd0)
                begin
                    if (state_reg == gscc_pkg::ST_DIVR)
                    begin
                        sr_next = dr_reg[17] ? -PW'(quo_reg) : PW'(quo_reg);
                        state_next = gscc_pkg::ST_DIVC;
                        cnt_next = 6'(DW);
                        drem_next = '0;
                        quo_next = '0;
                    end
                    else
                    begin
                        sc_next = dc_reg[17] ? -PW'(quo_reg) : PW'(quo_reg);
                        state_next = gscc_pkg::ST_READ;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (!dtrial[DW])
                    begin
                        drem_next = dtrial[DW-1:0];
                        quo_next = {quo_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_next = {drem_reg[DW-2:0], dnum_abs[didx]};
                        quo_next = {quo_reg[QW-2:0], 1'b0};
                    end
                end
            end
            gscc_pkg::ST_READ:
            begin
                // address issued this cycle, data next
                cell_out_next = pout;
                state_next = gscc_pkg::ST_STEP;
            end
            gscc_pkg::ST_STEP:
            begin
                if (cell_out_reg || rdata)
                begin
                    blocked_next = 1'b1;
                    state_next = gscc_pkg::ST_DONE;
                end
                else if (n_reg == NW'(1))
                begin
                    blocked_next = 1'b0;
                    state_next = gscc_pkg::ST_DONE;
                end
                else
                begin
                    n_next = n_reg - 1'b1;
                    pr_next = pr_reg + sr_reg;
                    pc_next = pc_reg + sc_reg;
                    state_next = gscc_pkg::ST_READ;
                end
            end
            gscc_pkg::ST_DONE:
            begin
                out_valid_next = 1'b1;
                state_next = gscc_pkg::ST_IDLE;
            end
            default: state_next = gscc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            orow_reg <= obstacle_row;
            ocol_reg <= obstacle_col;
            dr_reg <= 18'(to_row) - 18'(from_row);
            dc_reg <= 18'(to_col) - 18'(from_col);
            to_row_r <= to_row;
            to_col_r <= to_col;
        end
        pr_reg <= pr_next;
        pc_reg <= pc_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
        quo_reg <= quo_next;
        drem_reg <= drem_next;
        sr_reg <= sr_next;
        sc_reg <= sc_next;
        n_reg <= n_next;
        short_reg <= short_next;
        cell_out_reg <= cell_out_next;
        blocked_reg <= blocked_next;
        ka_reg <= ka_next;
        kb_reg <= kb_next;
        mark_c_reg <= mark_c_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gscc_pkg::ST_CLEAR;
            clr_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(blocked))
    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, out_valid |-> in_stall)
    `ASSERT_IMPL(a_clear_no_write_other, clk, rst_n,
        (state_reg == gscc_pkg::ST_CLEAR) |-> (we && !wdata))
endmodule
